// ===== rtl/core/ssdbd_pkg.sv =====
package ssdbd_pkg;

    localparam int OFS_W    = 16;
    localparam int ANC_W    = 16;
    localparam int CLASS_W  = 8;
    localparam int SCORE_W  = 16;
    localparam int HALF_W   = 18;
    localparam int CEN_W    = 18;
    localparam int CORNER_W = 20;

    // cycles from an input transfer to the half-size result
    localparam int EXP_LAT = 14;
    // cycles from an input transfer to the result strobe
    localparam int OUT_LAT = EXP_LAT + 1;
    // delay of the centre value after its own two stages
    localparam int CEN_DLY = EXP_LAT - 2;

    // reciprocals for exact floor division by small constants
    localparam logic [19:0] RCP5_Q22 = 20'd838861;
    localparam logic [20:0] RCP5_Q23 = 21'd1677722;
    localparam logic [22:0] RCP3_Q24 = 23'd5592406;

    typedef logic signed [OFS_W-1:0]    offset_t;
    typedef logic [ANC_W-1:0]           anchor_t;
    typedef logic [HALF_W-1:0]          half_t;
    typedef logic signed [CEN_W-1:0]    centre_t;
    typedef logic signed [CORNER_W-1:0] corner_t;

    localparam logic signed [CORNER_W:0] CORNER_MAX = 21'sd524287;
    localparam logic signed [CORNER_W:0] CORNER_MIN = -21'sd524288;

    function automatic corner_t sat_corner(input logic signed [CORNER_W:0] v);
        corner_t res;
        if (v > CORNER_MAX)
        begin
            res = CORNER_MAX[CORNER_W-1:0];
        end
        else if (v < CORNER_MIN)
        begin
            res = CORNER_MIN[CORNER_W-1:0];
        end
        else
        begin
            res = v[CORNER_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/ssdbd_half_size.sv =====
module ssdbd_half_size
    import ssdbd_pkg::*;
(
    input  logic    clk,
    input  offset_t offset,
    input  anchor_t size,
    output half_t   half
);

    // stage 1: r = 3276*t + floor((4t+2)/5)
    logic signed [17:0] z1;
    logic signed [19:0] x1_s;
    logic [38:0]        rcp_next, rcp_reg;
    logic signed [27:0] tk_next, tk_reg;

    // stage 2
    logic signed [27:0] r_next, r2_reg;

    // stage 3: r squared
    logic signed [55:0] sq_next, sq_reg;
    logic signed [27:0] r3_reg;

    // stage 4: r2 times r
    logic [22:0]        rsq_next, rsq4_reg;
    logic signed [51:0] p4_next, p4_reg;
    logic signed [27:0] r4_reg;

    // stage 5: floor division by three
    logic signed [21:0] q5;
    logic signed [22:0] x5_s;
    logic [44:0]        p5_next, p5_reg;
    logic signed [27:0] r5_reg;
    logic [22:0]        rsq5_reg;

    // stage 6
    logic signed [21:0] r3w;
    logic signed [19:0] cube_next, cube6_reg;
    logic signed [27:0] r6_reg;
    logic [22:0]        rsq6_reg;

    // stage 7: r3 times r
    logic signed [47:0] p7_next, p7_reg;
    logic signed [19:0] cube7_reg;
    logic signed [27:0] r7_reg;
    logic [22:0]        rsq7_reg;

    // stage 8 to 12: series sum, then four squarings
    logic signed [15:0] quart8;
    logic signed [32:0] e0_sum;
    logic [32:0]        e_next [0:4];
    logic [32:0]        e_reg  [0:4];
    logic [65:0]        esq    [0:3];

    // stage 13 and 14: scale by anchor size
    logic [48:0]        p13_next, p13_reg;
    logic [48:0]        half_sum;
    half_t              half_next, half_reg;

    anchor_t            size_reg [0:EXP_LAT-3];

    always_comb
    begin
        z1       = {offset, 2'b10};
        x1_s     = $signed({{2{z1[17]}}, z1}) + 20'sd163840;
        rcp_next = x1_s[18:0] * RCP5_Q22;
        tk_next  = $signed({{12{offset[OFS_W-1]}}, offset}) * 28'sd3276;

        r_next   = tk_reg + $signed({11'd0, rcp_reg[38:22]}) - 28'sd32768;

        sq_next  = r2_reg * r2_reg;

        rsq_next = sq_reg[53:31];
        p4_next  = $signed({1'b0, rsq_next}) * r3_reg;

        q5       = $signed(p4_reg[51:30]);
        x5_s     = $signed({q5[21], q5}) + 23'sd3145728;
        p5_next  = x5_s[21:0] * RCP3_Q24;

        r3w       = $signed({1'b0, p5_reg[44:24]}) - 22'sd1048576;
        cube_next = r3w[19:0];

        p7_next  = cube6_reg * r6_reg;

        quart8   = $signed(p7_reg[47:32]);
        e0_sum   = 33'sd1073741824 + r7_reg + $signed({1'b0, rsq7_reg}) + cube7_reg + quart8;
        e_next[0] = e0_sum[32:0];
        for (int k = 0; k < 4; k++)
        begin
            esq[k]      = e_reg[k] * e_reg[k] + 66'd536870912;
            e_next[k+1] = esq[k][62:30];
        end

        p13_next  = e_reg[4] * size_reg[EXP_LAT-3];
        half_sum  = p13_reg + 49'd1073741824;
        half_next = half_sum[48:31];
    end

    always_ff @(posedge clk)
    begin
        rcp_reg   <= rcp_next;
        tk_reg    <= tk_next;
        r2_reg    <= r_next;
        sq_reg    <= sq_next;
        r3_reg    <= r2_reg;
        rsq4_reg  <= rsq_next;
        p4_reg    <= p4_next;
        r4_reg    <= r3_reg;
        p5_reg    <= p5_next;
        r5_reg    <= r4_reg;
        rsq5_reg  <= rsq4_reg;
        cube6_reg <= cube_next;
        r6_reg    <= r5_reg;
        rsq6_reg  <= rsq5_reg;
        p7_reg    <= p7_next;
        cube7_reg <= cube6_reg;
        r7_reg    <= r6_reg;
        rsq7_reg  <= rsq6_reg;
        for (int k = 0; k < 5; k++)
        begin
            e_reg[k] <= e_next[k];
        end
        p13_reg  <= p13_next;
        half_reg <= half_next;
        size_reg[0] <= size;
        for (int i = 1; i < EXP_LAT - 2; i++)
        begin
            size_reg[i] <= size_reg[i-1];
        end
    end

    assign half = half_reg;

endmodule

// ===== rtl/core/ssd_box_decode_unit.sv =====
// SSD anchor box decode, one detection per transfer.
// Input: drive the offsets, the anchor, class_in and score_in with start
// high; the transfer happens at a rising edge with start high and busy low.
// busy stays low, so a new item may be given in every cycle.
// Output: done is high for exactly one cycle with box_top, box_left,
// box_bottom, box_right, class_out and score_out of one item; the receiver
// must take it in that cycle, results come in input order.
// Throughput: one item per cycle. The longest path is the exp(t/5)
// evaluation: a series in r = t/80 (three dependent products) followed by
// four squarings, each product in a stage of its own, then the scaling by
// the anchor size.
// Corners are signed Q3.16 and saturate at their range.
// Reset clears the valid bits of the pipeline; items in flight are dropped
// and done stays low until fresh items come through.
module ssd_box_decode_unit
    import ssdbd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  offset_t             offset_y,
    input  offset_t             offset_x,
    input  offset_t             offset_h,
    input  offset_t             offset_w,
    input  anchor_t             anchor_y_center,
    input  anchor_t             anchor_x_center,
    input  anchor_t             anchor_height,
    input  anchor_t             anchor_width,
    input  logic [CLASS_W-1:0]  class_in,
    input  logic [SCORE_W-1:0]  score_in,
    output corner_t             box_top,
    output corner_t             box_left,
    output corner_t             box_bottom,
    output corner_t             box_right,
    output logic [CLASS_W-1:0]  class_out,
    output logic [SCORE_W-1:0]  score_out
);

    logic [OUT_LAT-1:0] valid_reg, valid_next;
    logic               accept;

    logic signed [32:0] cy_prod_next, cy_prod_reg, cx_prod_next, cx_prod_reg;
    anchor_t            ay_reg [0:1];
    anchor_t            ax_reg [0:1];

    logic signed [33:0] cy_sum, cx_sum;
    logic signed [20:0] cy_q, cx_q, cy_x, cx_x;
    logic [40:0]        cy_mul_next, cy_mul_reg, cx_mul_next, cx_mul_reg;

    logic signed [19:0] ycen_w, xcen_w;
    centre_t            ycen_reg [0:CEN_DLY-1];
    centre_t            xcen_reg [0:CEN_DLY-1];

    half_t              half_h, half_w;

    logic signed [CORNER_W:0] top_w, left_w, bottom_w, right_w;
    corner_t top_next, left_next, bottom_next, right_next;
    corner_t top_reg, left_reg, bottom_reg, right_reg;

    logic [CLASS_W-1:0] class_reg [0:OUT_LAT-1];
    logic [SCORE_W-1:0] score_reg [0:OUT_LAT-1];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    ssdbd_half_size u_half_h (
        .clk    (clk),
        .offset (offset_h),
        .size   (anchor_height),
        .half   (half_h)
    );

    ssdbd_half_size u_half_w (
        .clk    (clk),
        .offset (offset_w),
        .size   (anchor_width),
        .half   (half_w)
    );

    // centre: anchor + floor((t*size + 20480) / 40960)
    always_comb
    begin
        valid_next = {valid_reg[OUT_LAT-2:0], accept};

        cy_prod_next = offset_y * $signed({1'b0, anchor_height});
        cx_prod_next = offset_x * $signed({1'b0, anchor_width});

        cy_sum      = cy_prod_reg + 34'sd20480;
        cx_sum      = cx_prod_reg + 34'sd20480;
        cy_q        = cy_sum[33:13];
        cx_q        = cx_sum[33:13];
        cy_x        = cy_q + 21'sd327680;
        cx_x        = cx_q + 21'sd327680;
        cy_mul_next = cy_x[19:0] * RCP5_Q23;
        cx_mul_next = cx_x[19:0] * RCP5_Q23;

        ycen_w = $signed({4'd0, ay_reg[1]}) + $signed({2'd0, cy_mul_reg[40:23]}) - 20'sd65536;
        xcen_w = $signed({4'd0, ax_reg[1]}) + $signed({2'd0, cx_mul_reg[40:23]}) - 20'sd65536;

        top_w    = $signed({{3{ycen_reg[CEN_DLY-1][CEN_W-1]}}, ycen_reg[CEN_DLY-1]})
                   - $signed({3'd0, half_h});
        bottom_w = $signed({{3{ycen_reg[CEN_DLY-1][CEN_W-1]}}, ycen_reg[CEN_DLY-1]})
                   + $signed({3'd0, half_h});
        left_w   = $signed({{3{xcen_reg[CEN_DLY-1][CEN_W-1]}}, xcen_reg[CEN_DLY-1]})
                   - $signed({3'd0, half_w});
        right_w  = $signed({{3{xcen_reg[CEN_DLY-1][CEN_W-1]}}, xcen_reg[CEN_DLY-1]})
                   + $signed({3'd0, half_w});

        top_next    = sat_corner(top_w);
        bottom_next = sat_corner(bottom_w);
        left_next   = sat_corner(left_w);
        right_next  = sat_corner(right_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload pipeline, no reset
    always_ff @(posedge clk)
    begin
        cy_prod_reg <= cy_prod_next;
        cx_prod_reg <= cx_prod_next;
        ay_reg[0]   <= anchor_y_center;
        ax_reg[0]   <= anchor_x_center;
        ay_reg[1]   <= ay_reg[0];
        ax_reg[1]   <= ax_reg[0];
        cy_mul_reg  <= cy_mul_next;
        cx_mul_reg  <= cx_mul_next;
        ycen_reg[0] <= ycen_w[CEN_W-1:0];
        xcen_reg[0] <= xcen_w[CEN_W-1:0];
        for (int i = 1; i < CEN_DLY; i++)
        begin
            ycen_reg[i] <= ycen_reg[i-1];
            xcen_reg[i] <= xcen_reg[i-1];
        end
        top_reg    <= top_next;
        left_reg   <= left_next;
        bottom_reg <= bottom_next;
        right_reg  <= right_next;
        class_reg[0] <= class_in;
        score_reg[0] <= score_in;
        for (int i = 1; i < OUT_LAT; i++)
        begin
            class_reg[i] <= class_reg[i-1];
            score_reg[i] <= score_reg[i-1];
        end
    end

    assign done       = valid_reg[OUT_LAT-1];
    assign box_top    = top_reg;
    assign box_left   = left_reg;
    assign box_bottom = bottom_reg;
    assign box_right  = right_reg;
    assign class_out  = class_reg[OUT_LAT-1];
    assign score_out  = score_reg[OUT_LAT-1];

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import ssdbd_pkg::*;

    localparam int NUM_RANDOM  = 1530;
    localparam int CALM_TAIL   = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam longint Q30     = 64'sd1 << 30;

    typedef struct packed {
        offset_t              oy;
        offset_t              ox;
        offset_t              oh;
        offset_t              ow;
        anchor_t              ay;
        anchor_t              ax;
        anchor_t              ah;
        anchor_t              aw;
        logic [CLASS_W-1:0]   cls;
        logic [SCORE_W-1:0]   score;
    } det_t;

    typedef struct packed {
        corner_t              top;
        corner_t              left;
        corner_t              bottom;
        corner_t              right;
        logic [CLASS_W-1:0]   cls;
        logic [SCORE_W-1:0]   score;
    } box_t;

    typedef struct packed {
        det_t                 d;
        logic                 typed;
        box_t                 want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                done;
    offset_t             offset_y = '0;
    offset_t             offset_x = '0;
    offset_t             offset_h = '0;
    offset_t             offset_w = '0;
    anchor_t             anchor_y_center = '0;
    anchor_t             anchor_x_center = '0;
    anchor_t             anchor_height = '0;
    anchor_t             anchor_width = '0;
    logic [CLASS_W-1:0]  class_in = '0;
    logic [SCORE_W-1:0]  score_in = '0;
    corner_t             box_top;
    corner_t             box_left;
    corner_t             box_bottom;
    corner_t             box_right;
    logic [CLASS_W-1:0]  class_out;
    logic [SCORE_W-1:0]  score_out;

    logic                busy_s = 1'b1;
    int                  cycle_count = 0;
    int                  error_count = 0;
    int                  calm_left = 0;
    box_t                pending_boxes[$];
    box_t                due_box;
    dir_row_t            directed_rows[$];

    ssd_box_decode_unit uut (.*);

    always #2 clk = ~clk;

    function automatic longint div_floor(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint div_round(input longint a, input longint d);
        return div_floor(2 * a + d, 2 * d);
    endfunction

    // exp(t / 5) in q3.30: series in t/80, then squared four times
    function automatic longint unsigned scaled_exp(input longint t);
        longint r;
        longint r2;
        longint r3;
        longint r4;
        longint unsigned e;
        r  = div_round(t * 16384, 5);
        r2 = div_floor(r * r, 2 * Q30);
        r3 = div_floor(r2 * r, 3 * Q30);
        r4 = div_floor(r3 * r, 4 * Q30);
        e  = Q30 + r + r2 + r3 + r4;
        repeat (4)
        begin
            e = (e * e + (64'd1 << 29)) >> 30;
        end
        return e;
    endfunction

    function automatic longint half_extent(input longint t, input anchor_t size);
        longint unsigned p;
        p = scaled_exp(t) * longint'(size);
        return longint'((p + (64'd1 << 30)) >> 31);
    endfunction

    function automatic longint box_centre(input longint t, input anchor_t size,
                                          input anchor_t base);
        return longint'(base) + div_round(t * longint'(size), 40960);
    endfunction

    function automatic corner_t clamp_corner(input longint v);
        corner_t c;
        if (v > 524287)
        begin
            c = 20'sh7ffff;
        end
        else if (v < -524288)
        begin
            c = 20'sh80000;
        end
        else
        begin
            c = v[CORNER_W-1:0];
        end
        return c;
    endfunction

    function automatic box_t decode_box(input det_t d);
        box_t   b;
        longint yc;
        longint xc;
        longint hh;
        longint hw;
        yc = box_centre(longint'(d.oy), d.ah, d.ay);
        xc = box_centre(longint'(d.ox), d.aw, d.ax);
        hh = half_extent(longint'(d.oh), d.ah);
        hw = half_extent(longint'(d.ow), d.aw);
        b.top    = clamp_corner(yc - hh);
        b.left   = clamp_corner(xc - hw);
        b.bottom = clamp_corner(yc + hh);
        b.right  = clamp_corner(xc + hw);
        b.cls    = d.cls;
        b.score  = d.score;
        return b;
    endfunction

    function automatic offset_t rand_offset();
        logic [31:0] raw;
        offset_t     v;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: v = 16'sh7fff;
            1: v = 16'sh8000;
            2: v = '0;
            3: v = {{8{raw[7]}}, raw[7:0]};
            default: v = raw[15:0];
        endcase
        return v;
    endfunction

    function automatic anchor_t rand_anchor();
        logic [31:0] raw;
        anchor_t     v;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = 16'hffff;
            2: v = {8'd0, raw[7:0]};
            default: v = raw[15:0];
        endcase
        return v;
    endfunction

    function automatic det_t rand_det();
        det_t        d;
        logic [31:0] raw;
        raw     = $urandom;
        d.oy    = rand_offset();
        d.ox    = rand_offset();
        d.oh    = rand_offset();
        d.ow    = rand_offset();
        d.ay    = rand_anchor();
        d.ax    = rand_anchor();
        d.ah    = rand_anchor();
        d.aw    = rand_anchor();
        d.cls   = raw[7:0];
        d.score = raw[31:16];
        return d;
    endfunction

    function automatic void table_row(input offset_t oy, input offset_t ox,
                                      input offset_t oh, input offset_t ow,
                                      input anchor_t ay, input anchor_t ax,
                                      input anchor_t ah, input anchor_t aw,
                                      input logic [CLASS_W-1:0] cls,
                                      input logic [SCORE_W-1:0] score,
                                      input logic typed,
                                      input corner_t t, input corner_t l,
                                      input corner_t b, input corner_t r);
        dir_row_t row;
        row.d          = '{oy, ox, oh, ow, ay, ax, ah, aw, cls, score};
        row.typed      = typed;
        row.want       = '{t, l, b, r, cls, score};
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // one transfer; returns at the edge that takes it
    task automatic send_det(input det_t d, input logic typed, input box_t want);
        offset_y        <= d.oy;
        offset_x        <= d.ox;
        offset_h        <= d.oh;
        offset_w        <= d.ow;
        anchor_y_center <= d.ay;
        anchor_x_center <= d.ax;
        anchor_height   <= d.ah;
        anchor_width    <= d.aw;
        class_in        <= d.cls;
        score_in        <= d.score;
        start           <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy_s);
        pending_boxes.push_back(typed ? want : decode_box(d));
    endtask

    task automatic maybe_idle(input logic allowed);
        int gap;
        gap = 0;
        if (allowed)
        begin
            if (calm_left > 0)
            begin
                calm_left--;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                calm_left = $urandom_range(20, 60);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                gap = $urandom_range(1, 11);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sample away from the active edge
    always @(negedge clk)
    begin
        busy_s = busy;
        if (rst_n && done)
        begin
            if (pending_boxes.size() == 0)
            begin
                report_mismatch("result transfer with nothing pending");
            end
            else
            begin
                due_box = pending_boxes.pop_front();
                check_field("box_top", box_top, due_box.top);
                check_field("box_left", box_left, due_box.left);
                check_field("box_bottom", box_bottom, due_box.bottom);
                check_field("box_right", box_right, due_box.right);
                check_field("class_out", class_out, due_box.cls);
                check_field("score_out", score_out, due_box.score);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        // all zero
        table_row('0, '0, '0, '0, '0, '0, '0, '0, 8'd0, 16'd0,
                  1'b1, 20'sd0, 20'sd0, 20'sd0, 20'sd0);
        // zero anchor size: corners sit on the anchor centre
        table_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'hffff, 16'hffff, 16'h0000, 16'h0000, 8'd255, 16'hffff,
                  1'b1, 20'sd65535, 20'sd65535, 20'sd65535, 20'sd65535);
        table_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'd12345, 16'd54321, 16'h0000, 16'h0000, 8'd1, 16'd1,
                  1'b1, 20'sd12345, 20'sd54321, 20'sd12345, 20'sd54321);
        // zero offsets: exp is exactly one, half size rounds up
        table_row('0, '0, '0, '0, 16'd30000, 16'd100, 16'd40000, 16'd3, 8'd7, 16'h8000,
                  1'b1, 20'sd10000, 20'sd98, 20'sd50000, 20'sd102);
        // extremes
        table_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd255, 16'hffff,
                  1'b0, '0, '0, '0, '0);
        table_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd0, 16'hffff,
                  1'b0, '0, '0, '0, '0);
        table_row(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                  16'h0000, 16'h0000, 16'hffff, 16'hffff, 8'd128, 16'd0,
                  1'b0, '0, '0, '0, '0);
        table_row(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                  16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd127, 16'h7fff,
                  1'b0, '0, '0, '0, '0);
        table_row(16'shffff, 16'shffff, 16'shffff, 16'shffff,
                  16'd1, 16'd1, 16'd1, 16'd1, 8'd2, 16'd2,
                  1'b0, '0, '0, '0, '0);
        table_row(16'sd1, 16'sd1, 16'sd1, 16'sd1,
                  16'h8000, 16'h8000, 16'hffff, 16'hffff, 8'd3, 16'd3,
                  1'b0, '0, '0, '0, '0);
        table_row(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                  16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 8'h55, 16'haaaa,
                  1'b0, '0, '0, '0, '0);
        table_row(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
                  16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 8'haa, 16'h5555,
                  1'b0, '0, '0, '0, '0);
        table_row('0, '0, 16'sd8192, 16'sh6000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  8'd9, 16'd9, 1'b0, '0, '0, '0, '0);
        // centre offset landing on a half, both signs
        table_row(16'sd1, 16'shffff, '0, '0, 16'd1000, 16'd1000, 16'd20480, 16'd20480,
                  8'd10, 16'd10, 1'b0, '0, '0, '0, '0);
        table_row(16'sd3, 16'shfffd, 16'sd1, 16'shffff, 16'd0, 16'd65535, 16'd20480, 16'd20480,
                  8'd11, 16'd11, 1'b0, '0, '0, '0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_det(directed_rows[i].d, directed_rows[i].typed, directed_rows[i].want);
            maybe_idle(1'b1);
        end

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            send_det(rand_det(), 1'b0, '0);
            maybe_idle(i < NUM_RANDOM - CALM_TAIL);
        end
        start <= 1'b0;

        while (pending_boxes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (OUT_LAT + 4) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ssdbd_pkg.sv
rtl/core/ssdbd_half_size.sv
rtl/core/ssd_box_decode_unit.sv
test/tb_top.sv
